/* rtl/nfcrd_pkg.sv */
package nfcrd_pkg;

  localparam logic [7:0] ID_RESET  = 8'hD5;
  localparam logic [7:0] SOF_BYTE  = 8'hFF;
  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [3:0] MIN_BUF   = 4'd8;
  localparam logic [7:0] MIN_LEN   = 8'd2;

  typedef enum logic [6:0] {
    PH_HUNT = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_LCS  = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_DCS  = 7'b0010000,
    PH_POST = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FRAME = 2'd2
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

endpackage

/* rtl/nfc_response_frame_deframer_unit.sv */
// Response frame deframer: takes a receive buffer one byte per word on the
// input channel (byte_in_i, end_of_buffer_i marks the last byte), hunts for
// the 00 00 FF start sequence, checks length checksum, frame identifier,
// data checksum and postamble, and emits one output word per payload byte
// after the identifier plus one status word on the last byte of the buffer.
// The identifier is set through cfg_we_i / cfg_wdata_i (reset value D5).
// Both channels use valid/stall; a word moves when valid is high and stall
// is low.
// Data path: input register, then parse logic into the output register.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single-byte parse step.
// When the receiver stalls, the output word holds and the input register
// keeps accepting until it is full; in_stall_o then rises in the same cycle.
// Reset clears both stages and returns the parser to hunting for the start
// sequence with the identifier at its reset value. After every last byte
// the parser also returns to hunting; the identifier is left unchanged.
module nfc_response_frame_deframer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_buffer_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       result_kind_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] frame_status_o,
  output logic [7:0] payload_length_o,
  output logic       is_last_o
);

  logic [7:0] exp_id_q;

  // input register
  logic       v1_q;
  logic [7:0] byte_q;
  logic       last_q;

  // parser state
  nfcrd_pkg::phase_e  phase_q, phase_d;
  nfcrd_pkg::status_e held_q, held_d;
  logic [1:0] zrun_q, zrun_d;
  logic [7:0] flen_q, flen_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [3:0] bcnt_q, bcnt_d;
  logic       idm_q, idm_d;

  // output register
  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] pbyte_q;
  logic [1:0] stat_q;
  logic [7:0] plen_q;

  logic               adv;
  logic               emit_pay;
  logic [7:0]         sum_add;
  nfcrd_pkg::status_e fin_st;

  assign adv        = v1_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = v1_q && !adv;
  assign sum_add    = sum_q + byte_q;

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    zrun_d   = zrun_q;
    flen_d   = flen_q;
    left_d   = left_q;
    sum_d    = sum_q;
    idm_d    = idm_q;
    emit_pay = 1'b0;
    bcnt_d   = (bcnt_q < nfcrd_pkg::MIN_BUF) ? bcnt_q + 4'd1 : bcnt_q;
    unique case (phase_q)
      nfcrd_pkg::PH_HUNT: begin
        if (byte_q == nfcrd_pkg::ZERO_BYTE) begin
          if (zrun_q < 2'd2) zrun_d = zrun_q + 2'd1;
        end else begin
          if (byte_q == nfcrd_pkg::SOF_BYTE && zrun_q >= 2'd2) phase_d = nfcrd_pkg::PH_LEN;
          zrun_d = 2'd0;
        end
      end
      nfcrd_pkg::PH_LEN: begin
        flen_d  = byte_q;
        phase_d = nfcrd_pkg::PH_LCS;
      end
      nfcrd_pkg::PH_LCS: begin
        if ((flen_q + byte_q) != 8'd0 || flen_q < nfcrd_pkg::MIN_LEN) begin
          held_d  = nfcrd_pkg::ST_FRAME;
          phase_d = nfcrd_pkg::PH_DONE;
        end else begin
          left_d  = flen_q;
          sum_d   = 8'd0;
          phase_d = nfcrd_pkg::PH_DATA;
        end
      end
      nfcrd_pkg::PH_DATA: begin
        sum_d = sum_add;
        if (left_q == flen_q && byte_q != exp_id_q) begin
          // wrong identifier: decide at once, no count
          held_d  = nfcrd_pkg::ST_FRAME;
          phase_d = nfcrd_pkg::PH_DONE;
        end else begin
          if (left_q == flen_q) idm_d = 1'b1;
          else emit_pay = 1'b1;
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = nfcrd_pkg::PH_DCS;
        end
      end
      nfcrd_pkg::PH_DCS: begin
        sum_d = sum_add;
        if (sum_add != 8'd0) begin
          held_d  = nfcrd_pkg::ST_FRAME;
          phase_d = nfcrd_pkg::PH_DONE;
        end else begin
          phase_d = nfcrd_pkg::PH_POST;
        end
      end
      nfcrd_pkg::PH_POST: begin
        held_d  = (byte_q == nfcrd_pkg::ZERO_BYTE && idm_q) ?
                  nfcrd_pkg::ST_OK : nfcrd_pkg::ST_FRAME;
        phase_d = nfcrd_pkg::PH_DONE;
      end
      nfcrd_pkg::PH_DONE: begin
        // ignore bytes until the end marker
      end
      default: begin
        phase_d = nfcrd_pkg::PH_HUNT;
      end
    endcase
    fin_st = (bcnt_d < nfcrd_pkg::MIN_BUF) ? nfcrd_pkg::ST_SHORT : held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_id_q <= nfcrd_pkg::ID_RESET;
    end else if (cfg_we_i) begin
      exp_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      v1_q <= 1'b1;
    end else if (adv) begin
      v1_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= byte_in_i;
      last_q <= end_of_buffer_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nfcrd_pkg::PH_HUNT;
      held_q  <= nfcrd_pkg::ST_FRAME;
      zrun_q  <= 2'd0;
      flen_q  <= 8'd0;
      left_q  <= 8'd0;
      sum_q   <= 8'd0;
      bcnt_q  <= 4'd0;
      idm_q   <= 1'b0;
    end else if (adv) begin
      if (last_q) begin
        // end of buffer: back to hunting
        phase_q <= nfcrd_pkg::PH_HUNT;
        held_q  <= nfcrd_pkg::ST_FRAME;
        zrun_q  <= 2'd0;
        flen_q  <= 8'd0;
        left_q  <= 8'd0;
        sum_q   <= 8'd0;
        bcnt_q  <= 4'd0;
        idm_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        held_q  <= held_d;
        zrun_q  <= zrun_d;
        flen_q  <= flen_d;
        left_q  <= left_d;
        sum_q   <= sum_d;
        bcnt_q  <= bcnt_d;
        idm_q   <= idm_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last_q || emit_pay;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (last_q) begin
        kind_q  <= nfcrd_pkg::KIND_STATUS;
        pbyte_q <= 8'd0;
        stat_q  <= fin_st;
        plen_q  <= (fin_st == nfcrd_pkg::ST_OK) ? flen_d - 8'd1 : 8'd0;
      end else begin
        kind_q  <= nfcrd_pkg::KIND_PAYLOAD;
        pbyte_q <= byte_q;
        stat_q  <= nfcrd_pkg::ST_OK;
        plen_q  <= 8'd0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign payload_byte_o   = pbyte_q;
  assign frame_status_o   = stat_q;
  assign payload_length_o = plen_q;
  assign is_last_o        = kind_q;

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("parser phase not one-hot");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && last_q) |=> (phase_q == nfcrd_pkg::PH_HUNT && bcnt_q == 4'd0))
    else $error("parser did not restart after end of buffer");

  a_ok_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == nfcrd_pkg::KIND_STATUS &&
     frame_status_o == nfcrd_pkg::ST_OK) |-> (payload_length_o != 8'd0))
    else $error("ok status with zero payload length");

  a_payload_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o == nfcrd_pkg::KIND_PAYLOAD) |->
    (frame_status_o == nfcrd_pkg::ST_OK && payload_length_o == 8'd0 && !is_last_o))
    else $error("payload word carries status fields");

  a_no_stall_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side is free");

endmodule

/* tb/sv/nfc_response_frame_deframer_unit_tb.sv */
module nfc_response_frame_deframer_unit_tb;
  import nfcrd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] payload;
    status_e    status;
    logic [7:0] plen;
    logic       is_last;
  } deframe_word_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          eob;
    logic          typed;
    deframe_word_t w;
  } stim_row_t;

  localparam deframe_word_t W_NONE  = '0;
  localparam deframe_word_t W_SHORT = '{KIND_STATUS, 8'h00, ST_SHORT, 8'h00, 1'b1};
  localparam deframe_word_t W_FRAME = '{KIND_STATUS, 8'h00, ST_FRAME, 8'h00, 1'b1};
  localparam deframe_word_t W_OK2   = '{KIND_STATUS, 8'h00, ST_OK, 8'h02, 1'b1};

  // one-byte buffer, clean frame, bad length checksum, wrong identifier
  localparam stim_row_t DIR_ROWS [27] = '{
    '{8'hFF, 1'b1, 1'b1, W_SHORT},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'hFF, 1'b0, 1'b0, W_NONE},
    '{8'h03, 1'b0, 1'b0, W_NONE},
    '{8'hFD, 1'b0, 1'b0, W_NONE},
    '{8'hD5, 1'b0, 1'b0, W_NONE},
    '{8'hAB, 1'b0, 1'b0, W_NONE},
    '{8'hCD, 1'b0, 1'b0, W_NONE},
    '{8'hB3, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b1, 1'b1, W_OK2},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'hFF, 1'b0, 1'b0, W_NONE},
    '{8'h02, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h11, 1'b0, 1'b0, W_NONE},
    '{8'h22, 1'b1, 1'b1, W_FRAME},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'hFF, 1'b0, 1'b0, W_NONE},
    '{8'h02, 1'b0, 1'b0, W_NONE},
    '{8'hFE, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b0, 1'b0, W_NONE},
    '{8'h00, 1'b1, 1'b1, W_FRAME}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic [7:0] byte_in = 8'h00;
  logic       eob_in = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic [7:0] payload_length;
  logic       is_last;

  int send_idle = 0;
  int recv_stall = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycles = 0;

  deframe_word_t pending_words [$];
  logic [7:0]    buf_q [$];

  // parser shadow
  phase_e     parse_ph;
  logic [1:0] zero_run;
  logic [7:0] len_field;
  logic [7:0] bytes_left;
  logic [7:0] run_sum;
  logic [3:0] byte_cnt;
  logic       id_seen;
  status_e    held_st;
  logic [7:0] frame_id;

  nfc_response_frame_deframer_unit u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .byte_in_i        (byte_in),
    .end_of_buffer_i  (eob_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_kind_o    (result_kind),
    .payload_byte_o   (payload_byte),
    .frame_status_o   (frame_status),
    .payload_length_o (payload_length),
    .is_last_o        (is_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic clear_parser();
    parse_ph   = PH_HUNT;
    zero_run   = 2'd0;
    len_field  = 8'h00;
    bytes_left = 8'h00;
    run_sum    = 8'h00;
    byte_cnt   = 4'd0;
    id_seen    = 1'b0;
    held_st    = ST_FRAME;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic eob,
                              output bit got, output deframe_word_t w);
    bit         emit;
    logic [7:0] lcs_sum;
    status_e    st;
    emit = 1'b0;
    got  = 1'b0;
    w    = W_NONE;
    if (byte_cnt < MIN_BUF) byte_cnt++;
    case (parse_ph)
      PH_HUNT: begin
        if (b == ZERO_BYTE) begin
          if (zero_run < 2'd2) zero_run++;
        end else begin
          if (b == SOF_BYTE && zero_run >= 2'd2) parse_ph = PH_LEN;
          zero_run = 2'd0;
        end
      end
      PH_LEN: begin
        len_field = b;
        parse_ph  = PH_LCS;
      end
      PH_LCS: begin
        lcs_sum = len_field + b;
        if (lcs_sum != 8'h00 || len_field < MIN_LEN) begin
          held_st  = ST_FRAME;
          parse_ph = PH_DONE;
        end else begin
          bytes_left = len_field;
          run_sum    = 8'h00;
          parse_ph   = PH_DATA;
        end
      end
      PH_DATA: begin
        run_sum = run_sum + b;
        if (bytes_left == len_field && b != frame_id) begin
          held_st  = ST_FRAME;
          parse_ph = PH_DONE;
        end else begin
          if (bytes_left == len_field) id_seen = 1'b1;
          else emit = 1'b1;
          bytes_left--;
          if (bytes_left == 8'h00) parse_ph = PH_DCS;
        end
      end
      PH_DCS: begin
        run_sum = run_sum + b;
        if (run_sum != 8'h00) begin
          held_st  = ST_FRAME;
          parse_ph = PH_DONE;
        end else begin
          parse_ph = PH_POST;
        end
      end
      PH_POST: begin
        held_st  = (b == ZERO_BYTE && id_seen) ? ST_OK : ST_FRAME;
        parse_ph = PH_DONE;
      end
      default: ;
    endcase
    if (eob) begin
      st        = (byte_cnt < MIN_BUF) ? ST_SHORT : held_st;
      got       = 1'b1;
      w.kind    = KIND_STATUS;
      w.status  = st;
      w.plen    = (st == ST_OK) ? len_field - 8'd1 : 8'd0;
      w.is_last = 1'b1;
      clear_parser();
    end else if (emit) begin
      got       = 1'b1;
      w.kind    = KIND_PAYLOAD;
      w.payload = b;
    end
  endtask

  // Drive one word, hold it until taken, then predict what it yields.
  task automatic push_word(input logic [7:0] b, input logic eob, input bit pause,
                           input bit typed, input deframe_word_t fixed);
    bit            got;
    deframe_word_t w;
    if (pause) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_words.size() != 0);
    end
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    eob_in   <= eob;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    deframe_byte(b, eob, got, w);
    if (typed) pending_words.push_back(fixed);
    else if (got) pending_words.push_back(w);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0: return ZERO_BYTE;
      1: return SOF_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Build one buffer: mostly a framed response, sometimes damaged or cut.
  task automatic make_frame(input int force_len);
    bit         clean;
    int         len;
    int         keep;
    logic [7:0] d;
    logic [7:0] sum;
    clean = (force_len >= 0);
    buf_q = {};
    if (!clean && $urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) buf_q.push_back(noise_byte());
      return;
    end
    if (!clean) repeat ($urandom_range(0, 3)) buf_q.push_back(noise_byte());
    repeat ($urandom_range(2, 4)) buf_q.push_back(ZERO_BYTE);
    buf_q.push_back(SOF_BYTE);
    if (clean) len = force_len;
    else case ($urandom_range(19))
      0: len = $urandom_range(0, 1);
      1: len = $urandom_range(9, 40);
      default: len = $urandom_range(2, 7);
    endcase
    buf_q.push_back(8'(len));
    d = 8'(-len);
    if (!clean && $urandom_range(19) == 0) d = d + 8'($urandom_range(1, 255));
    buf_q.push_back(d);
    sum = 8'h00;
    for (int i = 0; i < len; i++) begin
      if (i == 0 && (clean || $urandom_range(19) != 0)) d = frame_id;
      else d = 8'($urandom);
      sum = sum + d;
      buf_q.push_back(d);
    end
    d = -sum;
    if (!clean && $urandom_range(19) == 0) d = d + 8'($urandom_range(1, 255));
    buf_q.push_back(d);
    if (!clean && $urandom_range(19) == 0) buf_q.push_back(8'($urandom_range(1, 255)));
    else buf_q.push_back(ZERO_BYTE);
    if (clean) return;
    repeat ($urandom_range(0, 2)) buf_q.push_back(noise_byte());
    if ($urandom_range(9) == 0) begin
      keep = $urandom_range(1, buf_q.size());
      while (buf_q.size() > keep) void'(buf_q.pop_back());
    end
  endtask

  task automatic send_buffer(input int pause_at);
    for (int i = 0; i < buf_q.size(); i++)
      push_word(buf_q[i], i == buf_q.size() - 1, i == pause_at, 1'b0, W_NONE);
  endtask

  task automatic note_mismatch(input string what, input deframe_word_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%s: want kind=%0d byte=%h st=%0d len=%0d last=%0b,",
             what, want.kind, want.payload, want.status, want.plen, want.is_last);
      $display(" got kind=%0d byte=%h st=%0d len=%0d last=%0b",
               result_kind, payload_byte, frame_status, payload_length, is_last);
    end
  endtask

  always @(posedge clk) begin : result_check
    deframe_word_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected word", W_NONE);
      end else begin
        want = pending_words.pop_front();
        if (result_kind !== want.kind || payload_byte !== want.payload ||
            frame_status !== want.status || payload_length !== want.plen ||
            is_last !== want.is_last)
          note_mismatch("word mismatch", want);
      end
    end
    out_stall <= (recv_stall != 0) && ($urandom_range(99) < recv_stall);
  end

  initial begin : stimulus
    int         start;
    logic [7:0] new_id;
    clear_parser();
    frame_id = ID_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[i])
      push_word(DIR_ROWS[i].b, DIR_ROWS[i].eob, 1'b0, DIR_ROWS[i].typed, DIR_ROWS[i].w);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph != 0) begin
        // drain the pipe before touching the identifier
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_words.size() != 0);
        repeat (4) @(posedge clk);
        case (ph)
          1: new_id = 8'h00;
          2: new_id = 8'hFF;
          3: new_id = 8'($urandom_range(1, 254));
          default: new_id = ID_RESET;
        endcase
        cfg_we    <= 1'b1;
        cfg_wdata <= new_id;
        @(posedge clk);
        cfg_we   <= 1'b0;
        frame_id = new_id;
      end
      case (ph)
        1: begin send_idle = 88; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 88; end
        3: begin send_idle = 28; recv_stall = 28; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      if (ph == 0) begin
        make_frame(255);
        send_buffer(-1);
      end
      if (ph == 2) begin
        make_frame(6);
        send_buffer(buf_q.size() / 2);
      end
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        make_frame(-1);
        send_buffer(-1);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* nfc_response_frame_deframer_unit.f */
rtl/nfcrd_pkg.sv
rtl/nfc_response_frame_deframer_unit.sv
tb/sv/nfc_response_frame_deframer_unit_tb.sv
